[src/rau_pkg.sv]
`default_nettype none

package rau_pkg;

	localparam int OPERAND_W = 16;
	localparam int NUM_W     = 33;
	localparam int DEN_W     = 32;
	localparam int OP_W      = 3;

	localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB      = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL      = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV      = 3'd3;
	localparam logic [OP_W-1:0] OP_SIMPLIFY = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]             operation;
		logic signed [OPERAND_W-1:0] a_num;
		logic signed [OPERAND_W-1:0] a_den;
		logic signed [OPERAND_W-1:0] b_num;
		logic signed [OPERAND_W-1:0] b_den;
	} req_item_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] result_num;
		logic signed [DEN_W-1:0] result_den;
		logic                    zero_gcd_error;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GCD_TEST,
		ST_GCD_WAIT,
		ST_QUO_NUM,
		ST_QUO_DEN,
		ST_DONE
	} rau_state_t;

endpackage

`default_nettype wire

[src/rational_arithmetic_unit_core.sv]
`default_nettype none

// channel  signals                 payload
// req      req_valid / req_stall   req  (operation, a_num, a_den, b_num, b_den)
// rsp      rsp_valid / rsp_stall   rsp  (result_num, result_den, zero_gcd_error)
//
// Add, subtract, multiply, divide: three products through one registered multiplier
// in ST_MUL, then the rsp register loads in ST_DONE. Unused codes go to ST_DONE.
// Simplify: each Euclid step runs one division in the bit-serial divider,
// up to about 23 steps, then the two quotients, or the error flag for a zero gcd.
// arst_n clears the sequencer and rsp_valid. req_stall is high while an item is in
// work; a finished result waits in the rsp register and the next item is taken.
module rational_arithmetic_unit_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire rau_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output rau_pkg::rsp_item_t rsp
);

	localparam int W = rau_pkg::OPERAND_W;

	rau_pkg::rau_state_t state_q, state_d;

	logic [rau_pkg::OP_W-1:0]  op_q;
	logic signed [W-1:0]       an_q, ad_q, bn_q, bd_q;
	logic [1:0]                step_q;
	logic signed [rau_pkg::NUM_W-1:0] p0_q, p1_q, num_q;
	logic signed [rau_pkg::DEN_W-1:0] den_q;
	logic                      err_q;
	logic signed [W-1:0]       p_q, q_q;
	logic                      rsp_valid_q;
	rau_pkg::rsp_item_t        rsp_q;

	logic signed [W-1:0]       mul_a, mul_b;
	logic signed [2*W-1:0]     prod;
	logic                      div_start;
	logic signed [W-1:0]       div_dividend, div_divisor;
	logic                      div_done;
	logic signed [W:0]         div_quo;
	logic signed [W-1:0]       div_rem;

	logic req_xfer, rsp_free, q_zero, p_zero;

	assign req_xfer = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign q_zero   = (q_q == '0);
	assign p_zero   = (p_q == '0);

	rau_mul #(.WIDTH(W)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	rau_div #(.WIDTH(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.operation)
						rau_pkg::OP_ADD, rau_pkg::OP_SUB,
						rau_pkg::OP_MUL, rau_pkg::OP_DIV: state_d = rau_pkg::ST_MUL;
						rau_pkg::OP_SIMPLIFY:             state_d = rau_pkg::ST_GCD_TEST;
						default:                          state_d = rau_pkg::ST_DONE;
					endcase
				end
			end
			rau_pkg::ST_MUL: begin
				if (step_q == 2'd3) state_d = rau_pkg::ST_DONE;
			end
			rau_pkg::ST_GCD_TEST: begin
				if (!q_zero)     state_d = rau_pkg::ST_GCD_WAIT;
				else if (p_zero) state_d = rau_pkg::ST_DONE;
				else             state_d = rau_pkg::ST_QUO_NUM;
			end
			rau_pkg::ST_GCD_WAIT: begin
				if (div_done) state_d = rau_pkg::ST_GCD_TEST;
			end
			rau_pkg::ST_QUO_NUM: begin
				if (div_done) state_d = rau_pkg::ST_QUO_DEN;
			end
			rau_pkg::ST_QUO_DEN: begin
				if (div_done) state_d = rau_pkg::ST_DONE;
			end
			rau_pkg::ST_DONE: begin
				if (rsp_free) state_d = rau_pkg::ST_IDLE;
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	// unit operand steering
	always_comb begin
		mul_a        = ad_q;
		mul_b        = bd_q;
		div_start    = 1'b0;
		div_dividend = p_q;
		div_divisor  = q_q;
		req_stall    = (state_q != rau_pkg::ST_IDLE);
		unique case (state_q)
			rau_pkg::ST_MUL: begin
				case (step_q)
					2'd0: begin
						mul_a = an_q;
						mul_b = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
					end
					2'd1: begin
						mul_a = bn_q;
						mul_b = ad_q;
					end
					default: begin
						mul_a = (op_q == rau_pkg::OP_DIV) ? bn_q : ad_q;
						mul_b = (op_q == rau_pkg::OP_DIV) ? ad_q : bd_q;
					end
				endcase
			end
			rau_pkg::ST_GCD_TEST: begin
				// q == 0 ends Euclid with gcd in p; first quotient is a_num / gcd
				if (q_zero) begin
					div_dividend = an_q;
					div_divisor  = p_q;
				end
				div_start = !(q_zero && p_zero);
			end
			rau_pkg::ST_QUO_NUM: begin
				div_dividend = ad_q;
				div_divisor  = p_q;
				div_start    = div_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::ST_IDLE;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rau_pkg::ST_MUL) step_q <= step_q + 1'b1;
			else                            step_q <= '0;
			if (state_q == rau_pkg::ST_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall)                         rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q  <= req.operation;
			an_q  <= req.a_num;
			ad_q  <= req.a_den;
			bn_q  <= req.b_num;
			bd_q  <= req.b_den;
			p_q   <= req.a_num;
			q_q   <= req.a_den;
			num_q <= '0;
			den_q <= '0;
			err_q <= 1'b0;
		end
		unique case (state_q)
			rau_pkg::ST_MUL: begin
				case (step_q)
					2'd1: p0_q <= rau_pkg::NUM_W'(prod);
					2'd2: p1_q <= rau_pkg::NUM_W'(prod);
					2'd3: begin
						den_q <= rau_pkg::DEN_W'(prod);
						case (op_q)
							rau_pkg::OP_ADD: num_q <= p0_q + p1_q;
							rau_pkg::OP_SUB: num_q <= p0_q - p1_q;
							default:         num_q <= p0_q;
						endcase
					end
					default: ;
				endcase
			end
			rau_pkg::ST_GCD_TEST: begin
				if (q_zero && p_zero) begin
					num_q <= rau_pkg::NUM_W'(an_q);
					den_q <= rau_pkg::DEN_W'(ad_q);
					err_q <= 1'b1;
				end
			end
			rau_pkg::ST_GCD_WAIT: begin
				if (div_done) begin
					p_q <= q_q;
					q_q <= div_rem;
				end
			end
			rau_pkg::ST_QUO_NUM: begin
				if (div_done) num_q <= rau_pkg::NUM_W'(div_quo);
			end
			rau_pkg::ST_QUO_DEN: begin
				if (div_done) den_q <= rau_pkg::DEN_W'(div_quo);
			end
			rau_pkg::ST_DONE: begin
				if (rsp_free) begin
					rsp_q.result_num     <= num_q;
					rsp_q.result_den     <= den_q;
					rsp_q.zero_gcd_error <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[src/rau_mul.sv]
`default_nettype none

module rau_mul #(
	parameter int WIDTH = 16
) (
	input  wire                       clk,
	input  wire  signed [WIDTH-1:0]   a,
	input  wire  signed [WIDTH-1:0]   b,
	output logic signed [2*WIDTH-1:0] prod
);

	logic signed [2*WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[src/rau_div.sv]
`default_nettype none

// Restoring divider on magnitudes, one quotient bit per cycle.
// Quotient truncates toward zero, remainder takes the dividend's sign.
module rau_div #(
	parameter int WIDTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  signed [WIDTH-1:0] dividend,
	input  wire  signed [WIDTH-1:0] divisor,
	output logic                    done,
	output logic signed [WIDTH:0]   quotient,
	output logic signed [WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH-1:0] rem_q;
	logic             qneg_q;
	logic             rneg_q;

	logic [WIDTH-1:0] dvd_mag;
	logic [WIDTH-1:0] dvs_mag;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             fits;

	// most negative operand wraps onto its own magnitude
	assign dvd_mag = dividend[WIDTH-1] ? WIDTH'(-dividend) : WIDTH'(dividend);
	assign dvs_mag = divisor[WIDTH-1] ? WIDTH'(-divisor) : WIDTH'(divisor);

	assign shifted = {rem_q, dvd_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = ~diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dvd_mag;
			dvs_q  <= dvs_mag;
			rem_q  <= '0;
			qneg_q <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
			rneg_q <= dividend[WIDTH-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			dvd_q <= {dvd_q[WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign remainder = rneg_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

`default_nettype wire

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rau_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [rau_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;
	localparam int STALL_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 600;
	localparam int PHASE_ITEMS   = 100;
	localparam int OPW           = rau_pkg::OPERAND_W;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	rau_pkg::req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rau_pkg::rsp_item_t rsp;

	rau_pkg::req_item_t pending_reqs[$];
	rau_pkg::rsp_item_t expected_results[$];
	rau_pkg::rsp_item_t want;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        idle_send[4] = '{0, 52, 0, 10};
	int        idle_recv[4] = '{0, 0, 52, 10};

	rational_arithmetic_unit_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Euclid with truncating remainder, so the gcd may come out negative.
	function automatic rau_pkg::rsp_item_t fraction_result(rau_pkg::req_item_t it);
		rau_pkg::rsp_item_t r;
		longint    an, ad, bn, bd, p, q, t;
		r  = '0;
		an = $signed(it.a_num);
		ad = $signed(it.a_den);
		bn = $signed(it.b_num);
		bd = $signed(it.b_den);
		case (it.operation)
			rau_pkg::OP_ADD: begin
				r.result_num = rau_pkg::NUM_W'(an * bd + bn * ad);
				r.result_den = rau_pkg::DEN_W'(ad * bd);
			end
			rau_pkg::OP_SUB: begin
				r.result_num = rau_pkg::NUM_W'(an * bd - bn * ad);
				r.result_den = rau_pkg::DEN_W'(ad * bd);
			end
			rau_pkg::OP_MUL: begin
				r.result_num = rau_pkg::NUM_W'(an * bn);
				r.result_den = rau_pkg::DEN_W'(ad * bd);
			end
			rau_pkg::OP_DIV: begin
				r.result_num = rau_pkg::NUM_W'(an * bd);
				r.result_den = rau_pkg::DEN_W'(bn * ad);
			end
			rau_pkg::OP_SIMPLIFY: begin
				p = an;
				q = ad;
				while (q != 0) begin
					t = p % q;
					p = q;
					q = t;
				end
				if (p == 0) begin
					r.result_num     = rau_pkg::NUM_W'(an);
					r.result_den     = rau_pkg::DEN_W'(ad);
					r.zero_gcd_error = 1'b1;
				end else begin
					r.result_num = rau_pkg::NUM_W'(an / p);
					r.result_den = rau_pkg::DEN_W'(ad / p);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int rand_operand();
		case ($urandom_range(7))
			0: return 0;
			1: return -(2 ** (OPW - 1));
			2: return 2 ** (OPW - 1) - 1;
			3: return int'($urandom_range(40)) - 20;
			default: return int'($urandom_range(2 ** OPW - 1)) - 2 ** (OPW - 1);
		endcase
	endfunction

	task automatic push_req(logic [rau_pkg::OP_W-1:0] op, int an, int ad, int bn, int bd);
		rau_pkg::req_item_t it;
		it.operation = op;
		it.a_num     = OPW'(an);
		it.a_den     = OPW'(ad);
		it.b_num     = OPW'(bn);
		it.b_den     = OPW'(bd);
		pending_reqs.push_back(it);
	endtask

	task automatic push_random_req();
		int sel, k;
		sel = int'($urandom_range(99));
		if (sel < 4) begin
			push_req(rau_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
				rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end else if (sel < 14) begin
			// shared factor so the reduction actually does something
			k = int'($urandom_range(300, 1));
			push_req(rau_pkg::OP_SIMPLIFY, k * (int'($urandom_range(200)) - 100),
				k * (int'($urandom_range(200)) - 100), rand_operand(), rand_operand());
		end else if (sel < 24) begin
			push_req(rau_pkg::OP_SIMPLIFY, rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
		end else begin
			push_req(rau_pkg::OP_W'($urandom_range(rau_pkg::OP_DIV, rau_pkg::OP_ADD)),
				rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end
	endtask

	// request side: hold the item until its transfer, then maybe idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall)
				expected_results.push_back(fraction_result(req));
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result num %0d den %0d err %0b", $time,
						rsp.result_num, rsp.result_den, rsp.zero_gcd_error);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_num !== want.result_num) begin
						$display("%0t: result_num expected %0d actual %0d", $time,
							want.result_num, rsp.result_num);
						mismatches++;
					end
					if (rsp.result_den !== want.result_den) begin
						$display("%0t: result_den expected %0d actual %0d", $time,
							want.result_den, rsp.result_den);
						mismatches++;
					end
					if (rsp.zero_gcd_error !== want.zero_gcd_error) begin
						$display("%0t: zero_gcd_error expected %0b actual %0b", $time,
							want.zero_gcd_error, rsp.zero_gcd_error);
						mismatches++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of the operands
		push_req(rau_pkg::OP_ADD, -32768, -32768, -32768, -32768);
		push_req(rau_pkg::OP_ADD, 32767, 32767, 32767, 32767);
		push_req(rau_pkg::OP_SUB, -32768, 32767, 32767, -32768);
		push_req(rau_pkg::OP_SUB, 32767, -32768, -32768, -32768);
		push_req(rau_pkg::OP_MUL, -32768, -32768, -32768, 32767);
		push_req(rau_pkg::OP_MUL, 32767, 32767, -32768, 32767);
		push_req(rau_pkg::OP_DIV, -32768, 32767, -32768, -32768);
		// zero denominators pass straight through
		push_req(rau_pkg::OP_ADD, 3, 0, 5, 7);
		push_req(rau_pkg::OP_DIV, 9, 4, 0, 2);
		push_req(rau_pkg::OP_MUL, 0, 0, 0, 0);
		// simplify: zero gcd, zero denominator, sign behavior, long Euclid chain
		push_req(rau_pkg::OP_SIMPLIFY, 0, 0, 123, -45);
		push_req(rau_pkg::OP_SIMPLIFY, 5, 0, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, -5, 0, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, 0, 7, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, -32768, -32768, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, -32768, 32767, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, 12, -18, -1, -1);
		push_req(rau_pkg::OP_SIMPLIFY, -12, 18, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, 28657, 17711, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, -32768, 16384, 0, 0);
		push_req(rau_pkg::OP_SIMPLIFY, -32768, -1, 0, 0);
		// unused codes give all zeros
		push_req(OP_UNUSED_LO, 1, 2, 3, 4);
		push_req(OP_UNUSED_LO + 3'd1, -1, -1, -1, -1);
		push_req(OP_UNUSED_HI, -32768, 32767, -32768, 32767);
		wait (pending_reqs.size() == 0 && expected_results.size() == 0);

		for (int ph = 0; ph < 4; ph++) begin
			@(posedge clk);
			send_idle_pct  = idle_send[ph];
			recv_stall_pct = idle_recv[ph];
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_random_req();
			wait (pending_reqs.size() == 0 && expected_results.size() == 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
